/* src/back_forward_nav_with_lru_history_core_assert.svh */
// assertion macros for the navigation core checker
`ifndef BACK_FORWARD_NAV_WITH_LRU_HISTORY_CORE_ASSERT_SVH
`define BACK_FORWARD_NAV_WITH_LRU_HISTORY_CORE_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define BFNAV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfnav check failed");

// next-cycle implication
`define BFNAV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfnav check failed");

`endif

/* src/bfnav_pkg.sv */
package bfnav_pkg;

    localparam int DATA_W           = 32;
    localparam int OP_W             = 2;
    localparam int NAV_DEPTH_DEF    = 16;
    localparam int RECENT_DEPTH_DEF = 5;
    localparam int SHOWN_RECENT     = 5;
    localparam int CNT_W            = 3;
    localparam int CNT_MAX          = 7;

    // result tdata layout, lowest bit up
    localparam int OFS_CUR_LINK  = 0;
    localparam int OFS_CUR_VALID = OFS_CUR_LINK + DATA_W;
    localparam int OFS_COUNT     = OFS_CUR_VALID + 1;
    localparam int OFS_RECENT    = OFS_COUNT + CNT_W;
    localparam int OUT_BITS      = OFS_RECENT + SHOWN_RECENT * DATA_W;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN = 2'd0,
        OP_BACK = 2'd1,
        OP_FWD  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic              en;
        logic [DATA_W-1:0] link;
    } t_touch;

endpackage

/* src/bfnav_recent.sv */
module bfnav_recent
    import bfnav_pkg::*;
#(
    parameter int RECENT_DEPTH = RECENT_DEPTH_DEF,
    localparam int FILL_W      = $clog2(RECENT_DEPTH + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_touch                               i_touch,
    output logic [RECENT_DEPTH-1:0][DATA_W-1:0]  o_list,
    output logic [FILL_W-1:0]                    o_fill
);

    localparam int IDX_W = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;

    logic [RECENT_DEPTH-1:0][DATA_W-1:0] r_list;
    logic [RECENT_DEPTH-1:0][DATA_W-1:0] n_list;
    logic [FILL_W-1:0]                   r_fill;
    logic [FILL_W-1:0]                   n_fill;
    logic [RECENT_DEPTH-1:0]             hit;
    logic                                found;
    logic [IDX_W-1:0]                    pos;

    always_comb begin
        for (int i = 0; i < RECENT_DEPTH; i++) begin
            hit[i] = (FILL_W'(i) < r_fill) && (r_list[i] == i_touch.link);
        end
        found = |hit;
        pos   = '0;
        // lowest matching slot wins
        for (int i = RECENT_DEPTH - 1; i >= 0; i--) begin
            if (hit[i]) begin
                pos = IDX_W'(i);
            end
        end
        n_fill = r_fill;
        if (!found) begin
            if (r_fill < FILL_W'(RECENT_DEPTH)) begin
                n_fill = r_fill + 1'b1;
                pos    = IDX_W'(r_fill);
            end else begin
                pos = IDX_W'(RECENT_DEPTH - 1);
            end
        end
        // shift every slot below the vacated one up by one, newest link into slot 0
        n_list[0] = i_touch.link;
        for (int i = 1; i < RECENT_DEPTH; i++) begin
            n_list[i] = (IDX_W'(i) <= pos) ? r_list[i-1] : r_list[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_touch.en) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_touch.en) begin
            r_list <= n_list;
        end
    end

    assign o_list = r_list;
    assign o_fill = r_fill;

endmodule

/* src/back_forward_nav_with_lru_history_core.sv */
// channel   dir   handshake             payload
// s         in    i_s_tvalid/o_s_tready tuser: opcode; tdata: link_value
// m         out   o_m_tvalid/i_m_tready tdata: current page and recency list
//
// open, unused opcode and back/forward with no page: result loaded straight from ST_IDLE
// back/forward with a page: registered read of the page ring, then ST_READ loads the result
// s is ready only in ST_IDLE, when the result slot is empty or its transfer happens that cycle
// i_rst_n is synchronous; the page ring itself needs no clearing after reset
// a stalled m holds off s at once, for as long as the result waits
module back_forward_nav_with_lru_history_core
    import bfnav_pkg::*;
#(
    parameter int NAV_DEPTH    = NAV_DEPTH_DEF,
    parameter int RECENT_DEPTH = RECENT_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [DATA_W-1:0]      i_s_tdata,   // [31:0] link_value
    input  logic [OP_W-1:0]        i_s_tuser,   // [1:0] opcode
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [31:0] current_link, [32] current_valid, [35:33] recent_count,
    // [67:36] recent_0, [99:68] recent_1, [131:100] recent_2,
    // [163:132] recent_3, [195:164] recent_4, [199:196] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int NAV_W  = $clog2(NAV_DEPTH);
    localparam int FILL_W = $clog2(RECENT_DEPTH + 1);
    localparam logic [NAV_W-1:0] NAV_LAST = NAV_W'(NAV_DEPTH - 1);

    logic [DATA_W-1:0] nav_mem [NAV_DEPTH];

    t_state            r_state,      n_state;
    logic [NAV_W-1:0]  r_base,       n_base;
    logic [NAV_W-1:0]  r_cursor,     n_cursor;
    logic [NAV_W-1:0]  r_top,        n_top;
    logic              r_nonempty,   n_nonempty;
    logic [DATA_W-1:0] r_cur_link,   n_cur_link;
    logic              r_out_valid,  n_out_valid;
    logic [DATA_W-1:0] r_rd_data;

    logic              in_fire;
    logic              wr_en;
    logic              rd_en;
    logic              out_load;
    logic [NAV_W-1:0]  cursor_next;
    logic [NAV_W-1:0]  cursor_prev;
    logic [NAV_W-1:0]  base_next;
    t_op               op;
    t_touch            touch;

    logic [RECENT_DEPTH-1:0][DATA_W-1:0] rec_list;
    logic [FILL_W-1:0]                   rec_fill;
    logic [CNT_W-1:0]                    rec_count;
    logic [SHOWN_RECENT-1:0][DATA_W-1:0] rec_shown;

    assign cursor_next = (r_cursor == NAV_LAST) ? '0 : r_cursor + 1'b1;
    assign cursor_prev = (r_cursor == '0) ? NAV_LAST : r_cursor - 1'b1;
    assign base_next   = (r_base == NAV_LAST) ? '0 : r_base + 1'b1;

    // the recency list and page state only change when the result slot is free
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign op         = t_op'(i_s_tuser);

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_cursor   = r_cursor;
        n_top      = r_top;
        n_nonempty = r_nonempty;
        n_cur_link = r_cur_link;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        touch.en   = 1'b0;
        touch.link = i_s_tdata;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (op)
                        OP_OPEN: begin
                            if (!r_nonempty) begin
                                n_cursor   = r_base;
                                n_nonempty = 1'b1;
                            end else begin
                                // full ring: oldest page falls off
                                if (cursor_next == r_base) begin
                                    n_base = base_next;
                                end
                                n_cursor = cursor_next;
                            end
                            n_top      = n_cursor;
                            n_cur_link = i_s_tdata;
                            wr_en      = 1'b1;
                            touch.en   = 1'b1;
                            out_load   = 1'b1;
                        end
                        OP_BACK: begin
                            if (r_nonempty) begin
                                if (r_cursor != r_base) begin
                                    n_cursor = cursor_prev;
                                end
                                rd_en   = 1'b1;
                                n_state = ST_READ;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        OP_FWD: begin
                            if (r_nonempty) begin
                                if (r_cursor != r_top) begin
                                    n_cursor = cursor_next;
                                end
                                rd_en   = 1'b1;
                                n_state = ST_READ;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                touch.en   = 1'b1;
                touch.link = r_rd_data;
                n_cur_link = r_rd_data;
                out_load   = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= '0;
            r_cursor    <= '0;
            r_top       <= '0;
            r_nonempty  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_cursor    <= n_cursor;
            r_top       <= n_top;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_link <= n_cur_link;
    end

    // page ring: one write or one read per cycle, never both
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            nav_mem[n_cursor] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= nav_mem[n_cursor];
        end
    end

    bfnav_recent #(
        .RECENT_DEPTH (RECENT_DEPTH)
    ) u_recent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_touch (touch),
        .o_list  (rec_list),
        .o_fill  (rec_fill)
    );

    always_comb begin
        if (int'(rec_fill) > CNT_MAX) begin
            rec_count = CNT_W'(CNT_MAX);
        end else begin
            rec_count = CNT_W'(rec_fill);
        end
    end

    for (genvar k = 0; k < SHOWN_RECENT; k++) begin : g_shown
        if (k < RECENT_DEPTH) begin : g_live
            assign rec_shown[k] = (FILL_W'(k) < rec_fill) ? rec_list[k] : '0;
        end else begin : g_none
            assign rec_shown[k] = '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        {(OUT_TDATA_W - OUT_BITS){1'b0}},
        rec_shown,
        rec_count,
        r_nonempty,
        (r_nonempty ? r_cur_link : {DATA_W{1'b0}})
    };

endmodule

/* src/bfnav_chk.sv */
`include "back_forward_nav_with_lru_history_core_assert.svh"

module bfnav_chk
    import bfnav_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [DATA_W-1:0]      i_s_tdata,
    input logic [OP_W-1:0]        i_s_tuser,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic [DATA_W-1:0] cur_link;
    logic              cur_valid;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] newest;
    logic              open_fire;
    logic              shows_page;

    assign cur_link   = o_m_tdata[OFS_CUR_LINK +: DATA_W];
    assign cur_valid  = o_m_tdata[OFS_CUR_VALID];
    assign count      = o_m_tdata[OFS_COUNT +: CNT_W];
    assign newest     = o_m_tdata[OFS_RECENT +: DATA_W];
    assign open_fire  = i_s_tvalid && o_s_tready && (i_s_tuser == OP_OPEN);
    assign shows_page = o_m_tvalid && cur_valid && (newest == cur_link);

    // a stalled result transfer keeps its payload
    `BFNAV_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // an opened page is current and newest in the very next result
    `BFNAV_ASSERT_NXT(a_open_result, open_fire, shows_page && (cur_link == $past(i_s_tdata)))

    // the current page was always the last one touched
    `BFNAV_ASSERT_NOW(a_cur_is_newest, o_m_tvalid && cur_valid, (newest == cur_link) && (count != '0))

    // no page means no link and an empty recency list
    `BFNAV_ASSERT_NOW(a_empty_clean, o_m_tvalid && !cur_valid, (cur_link == '0) && (count == '0))

endmodule

bind back_forward_nav_with_lru_history_core bfnav_chk u_bfnav_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
